@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kway merge check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kway merge check failed");

`endif

@@ rtl/kwmh_pkg.sv @@
// Package for the k-way merge heap: command codes, entry type and defaults.
package kwmh_pkg;

  // Default number of merge ways, which is also the heap depth.
  localparam int KWMH_NUM_WAYS = 16;

  // Payload field widths.
  localparam int KEY_W   = 32;
  localparam int SRC_W   = 4;
  localparam int CMD_W   = 2;
  localparam int COUNT_W = 5;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXHAUST = 2'd2;

  // One heap slot: a signed key and the run it came from.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [SRC_W-1:0]        src;
  } entry_t;

endpackage

@@ rtl/kwmh_in_if.sv @@
// Command channel interface of the k-way merge heap.
interface kwmh_in_if
  import kwmh_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] value;
  logic [SRC_W-1:0]        source;

  modport source_mp (output valid, output cmd, output value, output source, input ready);
  modport sink (input valid, input cmd, input value, input source, output ready);
endinterface

@@ rtl/kwmh_out_if.sv @@
// Result channel interface of the k-way merge heap.
interface kwmh_out_if
  import kwmh_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] top_value;
  logic [SRC_W-1:0]        top_source;
  logic [COUNT_W-1:0]      entry_count;
  logic                    is_empty;
  logic                    bad_command;

  modport source_mp (output valid, output top_value, output top_source, output entry_count,
                     output is_empty, output bad_command, input ready);
  modport sink (input valid, input top_value, input top_source, input entry_count,
                input is_empty, input bad_command, output ready);
endinterface

@@ rtl/kwmh_heap_ram.sv @@
// Heap storage: one write port and two registered read ports.
module kwmh_heap_ram
  import kwmh_pkg::*;
#(
  parameter int DEPTH = KWMH_NUM_WAYS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output entry_t        rdata_a,
  output entry_t        rdata_b
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ rtl/kway_merge_min_heap.sv @@
// K-way merge heap: one word in, sift over the heap memory, one result word out.
// Refused commands go straight to the result; insert sifts up and replace sifts down;
// exhaust fetches the last entry and sifts it down, or goes straight out when it is the last.
// Each heap level is one sift step on the memory ports, using the shared compare unit going down.
// One word at a time: the next is taken once its result has loaded, and a stalled result holds it off.
// Reset (synchronous, rst_n low) empties the heap; the storage itself is not cleared.
module kway_merge_min_heap
  import kwmh_pkg::*;
#(
  parameter int NUM_WAYS = KWMH_NUM_WAYS
) (
  input logic            clk,
  input logic            rst_n,
  kwmh_in_if.sink        in_ch,
  kwmh_out_if.source_mp  out_ch
);

  localparam int AW = $clog2(NUM_WAYS);
  localparam int CW = $clog2(NUM_WAYS + 1);
  localparam int IW = CW + 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UP   = 6'b000010,
    S_LAST = 6'b000100,
    S_DN   = 6'b001000,
    S_OUT  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  entry_t        mov_r, mov_nxt;
  logic          bad_r, bad_nxt;
  entry_t        root_r;

  // Memory port signals.
  logic          mem_we;
  logic [CW-1:0] mem_wpos;
  entry_t        mem_wd;
  logic [IW-1:0] rd_idx_a, rd_idx_b;
  entry_t        rd_a, rd_b;

  // Output register.
  logic                    out_valid_r;
  logic                    out_load;
  logic signed [KEY_W-1:0] out_value_r;
  logic [SRC_W-1:0]        out_source_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic                    out_empty_r;
  logic                    out_bad_r;

  // Index helpers for the sift steps.
  logic [CW-1:0] up_idx;
  logic [CW-1:0] fill_par;
  logic [IW-1:0] l_idx, r_idx;
  logic          take_l, take_r;
  logic [CW-1:0] child;

  // Map a heap index onto a memory address; indexes past the end read slot zero.
  function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
    logic [AW-1:0] a;
    a = '0;
    if (idx < IW'(NUM_WAYS)) begin
      a = idx[AW-1:0];
    end
    return a;
  endfunction

  kwmh_heap_ram #(
    .DEPTH (NUM_WAYS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_wpos[AW-1:0]),
    .wdata   (mem_wd),
    .raddr_a (to_addr(rd_idx_a)),
    .raddr_b (to_addr(rd_idx_b)),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Parent and child positions of the current hole.
  assign up_idx   = (pos_r - CW'(1)) >> 1;
  assign fill_par = (fill_r - CW'(1)) >> 1;
  assign l_idx    = {pos_r, 1'b1};
  assign r_idx    = l_idx + IW'(1);

  // Shared compare unit for one sift-down level, strict signed compares.
  always_comb begin
    take_l = (l_idx < IW'(fill_r)) && (rd_a.key < mov_r.key);
    take_r = (r_idx < IW'(fill_r)) && (rd_b.key < (take_l ? rd_a.key : mov_r.key));
    child  = take_r ? CW'(r_idx) : CW'(l_idx);
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer: the moving entry stays in mov_r and is written once at its final slot.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    mov_nxt   = mov_r;
    bad_nxt   = bad_r;
    mem_we    = 1'b0;
    mem_wpos  = pos_r;
    mem_wd    = mov_r;
    rd_idx_a  = '0;
    rd_idx_b  = '0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          bad_nxt = 1'b0;
          unique case (in_ch.cmd)
            CMD_INSERT: begin
              if (fill_r == CW'(NUM_WAYS)) begin
                bad_nxt   = 1'b1;
                state_nxt = S_OUT;
              end else begin
                mov_nxt.key = in_ch.value;
                mov_nxt.src = in_ch.source;
                pos_nxt     = fill_r;
                fill_nxt    = fill_r + CW'(1);
                rd_idx_a    = IW'(fill_par);
                state_nxt   = S_UP;
              end
            end
            CMD_REPLACE: begin
              if (fill_r == '0) begin
                bad_nxt   = 1'b1;
                state_nxt = S_OUT;
              end else begin
                mov_nxt.key = in_ch.value;
                mov_nxt.src = root_r.src;
                pos_nxt     = '0;
                rd_idx_a    = IW'(1);
                rd_idx_b    = IW'(2);
                state_nxt   = S_DN;
              end
            end
            CMD_EXHAUST: begin
              if (fill_r == '0) begin
                bad_nxt   = 1'b1;
                state_nxt = S_OUT;
              end else begin
                fill_nxt = fill_r - CW'(1);
                rd_idx_a = IW'(fill_r - CW'(1));
                if (fill_r == CW'(1)) begin
                  state_nxt = S_OUT;
                end else begin
                  state_nxt = S_LAST;
                end
              end
            end
            default: begin
              bad_nxt   = 1'b1;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_OUT;
        end else if (mov_r.key < rd_a.key) begin
          // Parent moves down into the hole; the hole climbs one level.
          mem_we   = 1'b1;
          mem_wd   = rd_a;
          pos_nxt  = up_idx;
          rd_idx_a = IW'((up_idx - CW'(1)) >> 1);
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_LAST: begin
        mov_nxt   = rd_a;
        pos_nxt   = '0;
        rd_idx_a  = IW'(1);
        rd_idx_b  = IW'(2);
        state_nxt = S_DN;
      end
      S_DN: begin
        mem_we = 1'b1;
        if (take_l || take_r) begin
          // Smaller child moves up into the hole; the hole drops one level.
          mem_wd   = take_r ? rd_b : rd_a;
          pos_nxt  = child;
          rd_idx_a = {child, 1'b1};
          rd_idx_b = {child, 1'b1} + IW'(1);
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bad_r   <= bad_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, including a shadow copy of the root slot.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    mov_r <= mov_nxt;
    if (mem_we && (mem_wpos == '0)) begin
      root_r <= mem_wd;
    end
    if (out_load) begin
      out_value_r  <= (fill_r == '0) ? '0 : root_r.key;
      out_source_r <= (fill_r == '0) ? '0 : root_r.src;
      out_count_r  <= COUNT_W'(fill_r);
      out_empty_r  <= (fill_r == '0);
      out_bad_r    <= bad_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_value   = out_value_r;
  assign out_ch.top_source  = out_source_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.bad_command = out_bad_r;

endmodule

@@ rtl/kwmh_checker.sv @@
// Port-level checker for the k-way merge heap and its bind statement.
`include "assert_macros.svh"

module kwmh_checker
  import kwmh_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [KEY_W-1:0] top_value,
  input logic [SRC_W-1:0]        top_source,
  input logic [COUNT_W-1:0]      entry_count,
  input logic                    is_empty,
  input logic                    bad_command
);

  // The empty flag agrees with the reported count.
  `ASSERT_IMPLIES(a_empty_count, clk, rst_n, out_valid, is_empty == (entry_count == '0))

  // An empty heap reports a zero root.
  `ASSERT_IMPLIES(a_empty_zero, clk, rst_n, out_valid && is_empty,
                  (top_value == '0) && (top_source == '0))

  // Once a word is taken the block is busy on the following cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // A stalled result word holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
               out_valid && $stable(top_value) && $stable(top_source) &&
               $stable(entry_count) && $stable(bad_command))

endmodule

bind kway_merge_min_heap kwmh_checker u_kwmh_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .top_value   (out_ch.top_value),
  .top_source  (out_ch.top_source),
  .entry_count (out_ch.entry_count),
  .is_empty    (out_ch.is_empty),
  .bad_command (out_ch.bad_command)
);
